>>> hw/rtl/irpw_pkg.sv
// irpw_pkg: shared types and constants for the ir pulse-width frame sender
// no dependencies; used by the interfaces, the carrier generator and the top level
`default_nettype none

package irpw_pkg;

   localparam int NIBBLE_W    = 4;
   localparam int MSG_W       = 8;
   localparam int MSG_IDX_W   = 3;
   localparam int SEG_W       = 16;
   localparam int CARRIER_W   = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_TICKS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPACE_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_TICKS     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRIER_HALF  = 3'd5;

   // register reset values
   localparam logic [SEG_W-1:0]     RST_HEADER_TICKS = 16'd38400;
   localparam logic [SEG_W-1:0]     RST_ONE_TICKS    = 16'd19200;
   localparam logic [SEG_W-1:0]     RST_ZERO_TICKS   = 16'd9600;
   localparam logic [SEG_W-1:0]     RST_SPACE_TICKS  = 16'd9600;
   localparam logic [SEG_W-1:0]     RST_END_TICKS    = 16'd48000;
   localparam logic [CARRIER_W-1:0] RST_CARRIER_HALF = 8'd208;

   // per-tick control from the frame sequencer to the carrier generator
   typedef struct packed {
      logic step;        // a tick request is taken this cycle
      logic load;        // start request: carrier restarts before the tick
      logic run;         // a mark is in progress on this tick
      logic zero_level;  // mark ends: level drops, count is not cleared
      logic clear;       // new mark or frame end: count and level cleared
   } irpw_carrier_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/irpw_if.sv
// irpw_req_if / irpw_rsp_if: valid/ready channels of the ir frame sender
// depends on irpw_pkg
`default_nettype none

interface irpw_req_if import irpw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                start_req;
   logic [NIBBLE_W-1:0] player;
   logic [NIBBLE_W-1:0] damage;

   modport source (output valid, output start_req, output player, output damage,
                   input ready);
   modport sink   (input valid, input start_req, input player, input damage,
                   output ready);
endinterface

interface irpw_rsp_if import irpw_pkg::*; ();
   logic valid;
   logic ready;
   logic ir_out;
   logic mark_active;
   logic busy_res;
   logic frame_done;

   modport source (output valid, output ir_out, output mark_active, output busy_res,
                   output frame_done, input ready);
   modport sink   (input valid, input ir_out, input mark_active, input busy_res,
                   input frame_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/irpw_carrier.sv
// irpw_carrier: carrier phase counter and level for the ir frame sender
// depends on irpw_pkg
`default_nettype none

module irpw_carrier import irpw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire irpw_carrier_ctl_type ctl,
   input  wire logic [CARRIER_W-1:0] half_period,
   output logic                      level
);

   logic [CARRIER_W-1:0] count_ff, count_in, count_cur;
   logic                 level_ff, level_in, level_cur;

   // a start request restarts the carrier before the tick is output
   assign count_cur = ctl.load ? '0 : count_ff;
   assign level_cur = ctl.load ? 1'b0 : level_ff;
   assign level     = level_cur;

   always_comb begin
      count_in = count_cur;
      level_in = level_cur;
      if (ctl.run) begin
         if (count_cur == half_period) begin
            count_in = '0;
            level_in = ~level_cur;
         end else begin
            count_in = count_cur + 1'b1;
         end
      end
      if (ctl.clear) begin
         count_in = '0;
         level_in = 1'b0;
      end else if (ctl.zero_level) begin
         level_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         level_ff <= 1'b0;
      end else if (ctl.step) begin
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ir_pulse_width_frame_sender.sv
// ir_pulse_width_frame_sender: top level, frame sequencer, registers, result register
// depends on irpw_pkg, irpw_if and irpw_carrier
`default_nettype none

// Each request is one timer tick and gives exactly one response carrying the LED
// drive (ir_out), mark_active, busy_res and frame_done for that tick. A request with
// start_req set loads the message byte {player, damage} and (re)starts a frame:
// header mark, then FRAME_BITS times a space and a one- or zero-mark (msb first, bit
// positions above 7 send zero), then a space and the end mark. Each segment lasts
// its register value plus one tick; during marks ir_out is a carrier that toggles
// every carrier_half_period plus one ticks and restarts at level 0 with each mark.
// Segment lengths are read on every tick, so a register write takes effect at once.
// Rate: one request is taken per clock. The whole tick update is one pass of logic
// from the sequencer state to a single response register, so the response appears
// in the cycle after its request; req ready only drops while that response register
// is full and rsp ready is low. Registers are written through csr_wr_en,
// csr_index and csr_wdata; unused indexes are ignored.

module ir_pulse_width_frame_sender import irpw_pkg::*; #(
   parameter int FRAME_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   irpw_req_if.sink                    req_chan,
   irpw_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // marks begun after the header run 0 .. FRAME_BITS+1
   localparam int BitsW = $clog2(FRAME_BITS + 2);
   localparam int PosW  = (BitsW > MSG_IDX_W) ? BitsW : MSG_IDX_W + 1;
   localparam logic [BitsW-1:0] LastBits = BitsW'(FRAME_BITS + 1);

   // configuration registers
   logic [SEG_W-1:0]     header_ticks_ff, one_ticks_ff, zero_ticks_ff;
   logic [SEG_W-1:0]     space_ticks_ff, end_ticks_ff;
   logic [CARRIER_W-1:0] carrier_half_ff;

   // frame sequencer state
   logic [SEG_W-1:0] seg_count_ff, seg_count_in;
   logic [BitsW-1:0] bits_done_ff, bits_done_in;
   logic             in_mark_ff, in_mark_in;
   logic             sending_ff, sending_in;
   logic [MSG_W-1:0] frame_byte_ff, frame_byte_in;

   // response register
   logic rsp_valid_ff;
   logic rsp_ir_out_ff, rsp_mark_ff, rsp_busy_ff, rsp_done_ff;

   // tick view after a start request is applied
   logic             accept, start;
   logic [SEG_W-1:0] seg_cur;
   logic [BitsW-1:0] bits_cur;
   logic             mark_cur, send_cur;
   logic [MSG_W-1:0] byte_cur;

   logic [PosW-1:0]  bit_pos;
   logic             bit_one, last_seg, seg_end, frame_end;
   logic [SEG_W-1:0] mark_len, seg_limit;
   logic             carrier_level;
   irpw_carrier_ctl_type carrier_ctl;

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign start          = req_chan.start_req;

   assign seg_cur  = start ? '0 : seg_count_ff;
   assign bits_cur = start ? '0 : bits_done_ff;
   assign mark_cur = start | in_mark_ff;
   assign send_cur = start | sending_ff;
   assign byte_cur = start ? {req_chan.player, req_chan.damage} : frame_byte_ff;

   // data bit for the mark in progress, msb first
   assign bit_pos  = PosW'(FRAME_BITS) - PosW'(bits_cur);
   assign bit_one  = (bit_pos < PosW'(MSG_W)) && byte_cur[bit_pos[MSG_IDX_W-1:0]];
   assign last_seg = (bits_cur >= LastBits);

   always_comb begin
      priority if (bits_cur == '0) begin
         mark_len = header_ticks_ff;
      end else if (last_seg) begin
         mark_len = end_ticks_ff;
      end else if (bit_one) begin
         mark_len = one_ticks_ff;
      end else begin
         mark_len = zero_ticks_ff;
      end
   end

   assign seg_limit = mark_cur ? mark_len : space_ticks_ff;
   assign seg_end   = send_cur & (seg_cur == seg_limit);
   assign frame_end = seg_end & last_seg;

   // next sequencer state
   always_comb begin
      seg_count_in  = seg_cur;
      bits_done_in  = bits_cur;
      in_mark_in    = mark_cur;
      sending_in    = send_cur;
      frame_byte_in = byte_cur;
      if (send_cur) begin
         if (seg_end) begin
            seg_count_in = '0;
            if (last_seg) begin
               sending_in    = 1'b0;
               in_mark_in    = 1'b0;
               bits_done_in  = '0;
               frame_byte_in = '0;
            end else if (mark_cur) begin
               in_mark_in = 1'b0;
            end else begin
               bits_done_in = bits_cur + 1'b1;
               in_mark_in   = 1'b1;
            end
         end else begin
            seg_count_in = seg_cur + 1'b1;
         end
      end
   end

   // carrier runs only during marks; space to mark and frame end clear it
   assign carrier_ctl.step       = accept;
   assign carrier_ctl.load       = start;
   assign carrier_ctl.run        = send_cur & mark_cur;
   assign carrier_ctl.clear      = frame_end | (seg_end & ~mark_cur);
   assign carrier_ctl.zero_level = seg_end & mark_cur;

   irpw_carrier u_carrier (
      .clock       (clock),
      .reset       (reset),
      .ctl         (carrier_ctl),
      .half_period (carrier_half_ff),
      .level       (carrier_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff  <= '0;
         bits_done_ff  <= '0;
         in_mark_ff    <= 1'b0;
         sending_ff    <= 1'b0;
         frame_byte_ff <= '0;
      end else if (accept) begin
         seg_count_ff  <= seg_count_in;
         bits_done_ff  <= bits_done_in;
         in_mark_ff    <= in_mark_in;
         sending_ff    <= sending_in;
         frame_byte_ff <= frame_byte_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ir_out_ff <= send_cur & mark_cur & carrier_level;
         rsp_mark_ff   <= send_cur & mark_cur;
         rsp_busy_ff   <= send_cur;
         rsp_done_ff   <= frame_end;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ir_out      = rsp_ir_out_ff;
   assign rsp_chan.mark_active = rsp_mark_ff;
   assign rsp_chan.busy_res    = rsp_busy_ff;
   assign rsp_chan.frame_done  = rsp_done_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ticks_ff <= RST_HEADER_TICKS;
         one_ticks_ff    <= RST_ONE_TICKS;
         zero_ticks_ff   <= RST_ZERO_TICKS;
         space_ticks_ff  <= RST_SPACE_TICKS;
         end_ticks_ff    <= RST_END_TICKS;
         carrier_half_ff <= RST_CARRIER_HALF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_TICKS: header_ticks_ff <= csr_wdata;
            CSR_ONE_TICKS:    one_ticks_ff    <= csr_wdata;
            CSR_ZERO_TICKS:   zero_ticks_ff   <= csr_wdata;
            CSR_SPACE_TICKS:  space_ticks_ff  <= csr_wdata;
            CSR_END_TICKS:    end_ticks_ff    <= csr_wdata;
            CSR_CARRIER_HALF: carrier_half_ff <= csr_wdata[CARRIER_W-1:0];
            default: ;
         endcase
      end
   end

   // an idle sequencer holds no bit progress
   a_idle_bits_clear: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (bits_done_ff == '0) && !in_mark_ff)
      else $error("bit progress left over while idle");

   // bit progress never passes the end mark
   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_done_ff <= LastBits)
      else $error("bit progress beyond end mark");

   // a frame end leaves the sequencer idle
   a_frame_end_idle: assert property (@(posedge clock) disable iff (reset)
      accept && frame_end |=> !sending_ff)
      else $error("sequencer still busy after frame end");

   // every taken request shows a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("response missing after request");

endmodule

`default_nettype wire
